// ----- sv/ffba_pkg.sv -----
// Shared types, codes and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF = 256;
    localparam int ADDR_SPAN      = 256;
    localparam int POS_W          = 9;
    localparam int MAP_W          = 8;
    localparam int WORD_W         = 32;
    localparam int CNT_W          = 32;

    localparam logic [2:0] FN_ALLOC   = 3'd0;
    localparam logic [2:0] FN_FREE    = 3'd1;
    localparam logic [2:0] FN_RD_VAL  = 3'd2;
    localparam logic [2:0] FN_WR_VAL  = 3'd3;
    localparam logic [2:0] FN_RD_LINK = 3'd4;
    localparam logic [2:0] FN_WR_LINK = 3'd5;
    localparam logic [2:0] FN_CLEAR   = 3'd6;

    typedef struct packed {
        logic [2:0]               func;
        logic [7:0]               addr;
        logic [7:0]               size;
        logic signed [WORD_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]               alloc_addr;
        logic signed [WORD_W-1:0] read_data;
        logic [CNT_W-1:0]         alloc_count;
        logic [CNT_W-1:0]         free_count;
        logic [CNT_W-1:0]         deref_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic finish_alloc;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic req_alloc;
        logic hit;
        logic miss;
        logic out_free;
    } t_status;

endpackage

// ----- sv/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator: controller plus datapath.
//
// A block store of min(NUM_BLOCKS, 256) blocks with a first-fit allocator. Block 0 is the
// null address and is never granted. Each item carries a func code: alloc scans the run
// map from block 1, counting free blocks and jumping over each allocated run by its stored
// length, and grants the first start whose free span covers size (0 on no fit or size
// zero). Free clears the run mark at addr; read and write access the value or link word
// of a block; clear zeroes the three counters, which every result shows after the item's
// own update. A free, read or write at an address beyond the store changes nothing.
// Timing: one item is worked on at a time, and the next item is accepted in the cycle after
// the result is written. A non-alloc item goes from acceptance to the execute state, where
// it writes its result once the output register is free. An alloc visits one run-map entry
// per cycle while it scans (a free block, or the head of a run it jumps over), a rate set
// by the single read port of the run map; once it finds a fit or fails, it waits for the
// output register to be free. The result sits in an output register, so a new item is
// accepted while the last result still waits to be taken; the next result is held back
// until that register is free. Reset needs no clearing pass: per-block valid flops mark
// every block free at once.
module first_fit_block_allocator_unit #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffba_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffba_pkg::t_out_item o_out_item
);

    ffba_pkg::t_cmd    cmd;
    ffba_pkg::t_status status;

    // sequence each item: accept, scan or execute, write the result
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // hold the stores, scan position, counters and output register
    ffba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- sv/ffba_ctrl.sv -----
// Controller state machine of the first-fit block allocator.
module ffba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ffba_pkg::t_status i_status,
    output ffba_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.req_alloc ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                if (i_status.hit || i_status.miss) begin
                    // hold the outcome until the output register is free
                    if (i_status.out_free) begin
                        o_cmd.finish_alloc = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/ffba_datapath.sv -----
// Datapath of the first-fit block allocator: stores, scan registers, counters, output.
module ffba_datapath #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffba_pkg::t_in_item  i_in_item,
    input  ffba_pkg::t_cmd      i_cmd,
    output ffba_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffba_pkg::t_out_item o_out_item
);

    localparam int USABLE = (NUM_BLOCKS < ffba_pkg::ADDR_SPAN) ? NUM_BLOCKS
                                                               : ffba_pkg::ADDR_SPAN;
    localparam int AW = $clog2(USABLE);
    localparam int PW = ffba_pkg::POS_W;
    localparam int MW = ffba_pkg::MAP_W;
    localparam int WW = ffba_pkg::WORD_W;
    localparam int CW = ffba_pkg::CNT_W;
    localparam logic [PW-1:0] U_POS = PW'(USABLE);

    // stores
    logic [MW-1:0] mem_map [USABLE];
    logic [WW-1:0] mem_val [USABLE];
    logic [WW-1:0] mem_lnk [USABLE];
    logic [USABLE-1:0] r_map_vld;

    // request and scan state
    ffba_pkg::t_in_item r_req;
    logic [PW-1:0] r_start;
    logic [PW-1:0] r_pos;
    logic [7:0]    r_cnt;
    logic [PW-1:0] n_start;
    logic [PW-1:0] n_pos;
    logic [7:0]    n_cnt;

    logic [MW-1:0] r_map_rd;
    logic          r_map_vld_rd;
    logic [WW-1:0] r_val_rd;
    logic [WW-1:0] r_lnk_rd;
    logic [AW-1:0] map_rd_idx;

    logic [CW-1:0] r_alloc_cnt, r_free_cnt, r_deref_cnt;
    logic [CW-1:0] n_alloc_cnt, n_free_cnt, n_deref_cnt;

    logic                r_out_valid;
    ffba_pkg::t_out_item r_out;

    logic [MW-1:0] map_val;
    logic          blk_free;
    logic          in_range;
    logic [8:0]    cnt_inc;
    logic          hit;
    logic          miss;
    logic          addr_ok;
    logic [AW-1:0] addr_idx;
    logic [AW-1:0] start_idx;
    logic [WW-1:0] rd_word;

    assign map_val  = r_map_vld_rd ? r_map_rd : '0;
    assign blk_free = (map_val == '0);
    assign in_range = (r_pos < U_POS);
    assign cnt_inc  = {1'b0, r_cnt} + 9'd1;
    assign miss     = (r_req.size == '0) || !in_range;
    assign hit      = !miss && blk_free && (cnt_inc >= {1'b0, r_req.size});

    assign addr_ok   = ({1'b0, r_req.addr} < U_POS);
    assign addr_idx  = r_req.addr[AW-1:0];
    assign start_idx = r_start[AW-1:0];

    assign o_status.req_alloc = (i_in_item.func == ffba_pkg::FN_ALLOC);
    assign o_status.hit       = hit;
    assign o_status.miss      = miss;
    assign o_status.out_free  = !r_out_valid;

    // load starts the scan at block 1; a step advances one block or jumps over an allocated run
    always_comb begin
        n_start = r_start;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        if (i_cmd.load) begin
            n_start = PW'(1);
            n_pos   = PW'(1);
            n_cnt   = '0;
        end else if (i_cmd.step) begin
            if (blk_free) begin
                n_pos = r_pos + PW'(1);
                n_cnt = cnt_inc[7:0];
            end else begin
                n_pos   = r_pos + PW'(map_val);
                n_start = r_pos + PW'(map_val);
                n_cnt   = '0;
            end
        end
    end

    assign map_rd_idx = (i_cmd.load || i_cmd.step) ? n_pos[AW-1:0] : r_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_pos   <= n_pos;
        r_cnt   <= n_cnt;
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
    end

    // run map: payload in memory, entry validity in flip-flops
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_alloc && hit) begin
            mem_map[start_idx] <= r_req.size;
        end
        r_map_rd <= mem_map[map_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (i_cmd.finish_alloc && hit) begin
            r_map_vld[start_idx] <= 1'b1;
        end else if (i_cmd.exec && addr_ok && r_req.func == ffba_pkg::FN_FREE) begin
            r_map_vld[addr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_map_vld_rd <= r_map_vld[map_rd_idx];
    end

    // value and link words
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && addr_ok && r_req.func == ffba_pkg::FN_WR_VAL) begin
            mem_val[addr_idx] <= r_req.data;
        end
        if (i_cmd.load) begin
            r_val_rd <= mem_val[i_in_item.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && addr_ok && r_req.func == ffba_pkg::FN_WR_LINK) begin
            mem_lnk[addr_idx] <= r_req.data;
        end
        if (i_cmd.load) begin
            r_lnk_rd <= mem_lnk[i_in_item.addr[AW-1:0]];
        end
    end

    // counters
    always_comb begin
        n_alloc_cnt = r_alloc_cnt;
        n_free_cnt  = r_free_cnt;
        n_deref_cnt = r_deref_cnt;
        if (i_cmd.finish_alloc && hit) begin
            n_alloc_cnt = r_alloc_cnt + CW'(1);
        end
        if (i_cmd.exec) begin
            case (r_req.func)
                ffba_pkg::FN_FREE: begin
                    if (addr_ok) n_free_cnt = r_free_cnt + CW'(1);
                end
                ffba_pkg::FN_RD_VAL, ffba_pkg::FN_WR_VAL,
                ffba_pkg::FN_RD_LINK, ffba_pkg::FN_WR_LINK: begin
                    if (addr_ok) n_deref_cnt = r_deref_cnt + CW'(1);
                end
                ffba_pkg::FN_CLEAR: begin
                    n_alloc_cnt = '0;
                    n_free_cnt  = '0;
                    n_deref_cnt = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_deref_cnt <= '0;
        end else begin
            r_alloc_cnt <= n_alloc_cnt;
            r_free_cnt  <= n_free_cnt;
            r_deref_cnt <= n_deref_cnt;
        end
    end

    // pick the word a read returns; zero for everything else
    always_comb begin
        rd_word = '0;
        if (i_cmd.exec && addr_ok && r_req.func == ffba_pkg::FN_RD_VAL) begin
            rd_word = r_val_rd;
        end else if (i_cmd.exec && addr_ok && r_req.func == ffba_pkg::FN_RD_LINK) begin
            rd_word = r_lnk_rd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish_alloc || i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_alloc || i_cmd.exec) begin
            r_out.alloc_addr  <= (i_cmd.finish_alloc && hit) ? r_start[7:0] : 8'd0;
            r_out.read_data   <= rd_word;
            r_out.alloc_count <= n_alloc_cnt;
            r_out.free_count  <= n_free_cnt;
            r_out.deref_count <= n_deref_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- sv/ffba_checker.sv -----
// Port-level assertions for the first-fit block allocator, bound to the top level.
module ffba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ffba_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ffba_pkg::t_out_item o_out_item
);

    // a result waiting for the sink stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // a waiting result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result payload changed while stalled");

    // one item at a time: an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while busy");

    // a new result comes only from work on an accepted item
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a pending item");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the first-fit block allocator unit.
module tb;

    // Store geometry as the unit sees it: only 8-bit addresses are usable.
    localparam int BLOCKS = ffba_pkg::NUM_BLOCKS_DEF;
    localparam int USABLE = (BLOCKS < ffba_pkg::ADDR_SPAN) ? BLOCKS : ffba_pkg::ADDR_SPAN;

    // The package names no code for the spare func value.
    localparam logic [2:0] FN_SPARE = 3'd7;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_PCT     = 37;
    localparam int STEADY_FIRST = 300;
    localparam int STEADY_LAST  = 500;
    // Slowest item is a full scan of the run map; allow many times that.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    // One line of the directed table: the item and, where it is obvious, its result.
    typedef struct packed {
        ffba_pkg::t_in_item  item;
        logic                typed;
        ffba_pkg::t_out_item want;
    } t_plan_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_ready = 1'b0;
    ffba_pkg::t_in_item  in_item   = '0;
    logic                in_ready;
    logic                out_valid;
    ffba_pkg::t_out_item out_item;

    // Drop all idling on both sides while set.
    logic      no_idle   = 1'b0;

    // Shadow copy of the allocator state.
    logic [ffba_pkg::MAP_W-1:0]  run_map     [USABLE];
    logic [ffba_pkg::WORD_W-1:0] value_words [USABLE];
    logic [ffba_pkg::WORD_W-1:0] link_words  [USABLE];
    logic [ffba_pkg::CNT_W-1:0]  allocs_seen;
    logic [ffba_pkg::CNT_W-1:0]  frees_seen;
    logic [ffba_pkg::CNT_W-1:0]  accesses_seen;

    // Results owed by the unit, oldest first.
    ffba_pkg::t_out_item owed_results [$];
    t_plan_row           directed_plan [$];

    // Stimulus bookkeeping: granted starts still held, and words that hold data.
    logic [7:0]  live_starts [$];
    logic [7:0]  val_addrs   [$];
    logic [7:0]  link_addrs  [$];
    bit          val_seen    [256];
    bit          link_seen   [256];

    int          fail_count  = 0;
    int          stall_count = 0;
    int          n_alloc     = 0;
    int          n_granted   = 0;
    int          n_free      = 0;
    int          n_access    = 0;
    int          n_clear     = 0;
    int          n_spare     = 0;
    ffba_pkg::t_out_item oldest;

    first_fit_block_allocator_unit #(
        .NUM_BLOCKS (BLOCKS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one accepted item and advance the shadow state.
    function automatic ffba_pkg::t_out_item predict_allocator(input ffba_pkg::t_in_item it);
        ffba_pkg::t_out_item r;
        int        start;
        int        span;
        int        stop_pos;
        bit        scanning;
        bit        in_range;
        r        = '0;
        in_range = int'(it.addr) < USABLE;
        case (it.func)
            ffba_pkg::FN_ALLOC: begin
                // Walk from block 1: count free blocks, hop over each run by its length.
                scanning = (it.size != 8'd0);
                start    = 1;
                while (scanning && start < USABLE) begin
                    span = 0;
                    while (start + span < USABLE && run_map[start + span] == 8'd0)
                        span++;
                    stop_pos = start + span;
                    if (span >= int'(it.size)) begin
                        run_map[start] = it.size;
                        allocs_seen++;
                        r.alloc_addr = 8'(start);
                        scanning = 1'b0;
                    end else if (stop_pos >= USABLE) begin
                        // Free span ran into the end of the store: no fit.
                        scanning = 1'b0;
                    end else begin
                        start = stop_pos + int'(run_map[stop_pos]);
                    end
                end
            end
            ffba_pkg::FN_FREE: begin
                if (in_range) begin
                    run_map[it.addr] = 8'd0;
                    frees_seen++;
                end
            end
            ffba_pkg::FN_RD_VAL: begin
                if (in_range) begin
                    r.read_data = value_words[it.addr];
                    accesses_seen++;
                end
            end
            ffba_pkg::FN_WR_VAL: begin
                if (in_range) begin
                    value_words[it.addr] = it.data;
                    accesses_seen++;
                end
            end
            ffba_pkg::FN_RD_LINK: begin
                if (in_range) begin
                    r.read_data = link_words[it.addr];
                    accesses_seen++;
                end
            end
            ffba_pkg::FN_WR_LINK: begin
                if (in_range) begin
                    link_words[it.addr] = it.data;
                    accesses_seen++;
                end
            end
            ffba_pkg::FN_CLEAR: begin
                allocs_seen   = '0;
                frees_seen    = '0;
                accesses_seen = '0;
            end
            default: begin
            end
        endcase
        r.alloc_count = allocs_seen;
        r.free_count  = frees_seen;
        r.deref_count = accesses_seen;
        return r;
    endfunction

    // Draw one random request; reads only ever target words that hold data.
    function automatic ffba_pkg::t_in_item random_request();
        ffba_pkg::t_in_item it;
        int       pick;
        int       sel;
        it.func = FN_SPARE;
        it.addr = 8'($urandom);
        it.size = 8'($urandom);
        it.data = $urandom;
        pick    = $urandom_range(99);
        if (pick < 32) begin
            it.func = ffba_pkg::FN_ALLOC;
            sel = $urandom_range(99);
            if (sel < 4)
                it.size = 8'd0;
            else if (sel < 80)
                it.size = 8'($urandom_range(16, 1));
            else if (sel < 95)
                it.size = 8'($urandom_range(80, 17));
        end else if (pick < 56) begin
            it.func = ffba_pkg::FN_FREE;
            // Mostly release a held run; otherwise hit any block.
            if (live_starts.size() != 0 && $urandom_range(99) < 80)
                it.addr = live_starts[$urandom_range(live_starts.size() - 1)];
        end else if (pick < 66) begin
            it.func = ffba_pkg::FN_WR_VAL;
        end else if (pick < 76) begin
            it.func = ffba_pkg::FN_WR_LINK;
        end else if (pick < 86) begin
            if (val_addrs.size() != 0) begin
                it.func = ffba_pkg::FN_RD_VAL;
                it.addr = val_addrs[$urandom_range(val_addrs.size() - 1)];
            end else begin
                it.func = ffba_pkg::FN_WR_VAL;
            end
        end else if (pick < 95) begin
            if (link_addrs.size() != 0) begin
                it.func = ffba_pkg::FN_RD_LINK;
                it.addr = link_addrs[$urandom_range(link_addrs.size() - 1)];
            end else begin
                it.func = ffba_pkg::FN_WR_LINK;
            end
        end else if (pick < 98) begin
            it.func = ffba_pkg::FN_CLEAR;
        end
        return it;
    endfunction

    task automatic add_row(input logic [2:0] func, input logic [7:0] addr,
                           input logic [7:0] size, input logic [31:0] data,
                           input logic typed, input logic [7:0] a_addr,
                           input logic [31:0] rd, input logic [31:0] ac,
                           input logic [31:0] fc, input logic [31:0] dc);
        t_plan_row row;
        row.item.func        = func;
        row.item.addr        = addr;
        row.item.size        = size;
        row.item.data        = data;
        row.typed            = typed;
        row.want.alloc_addr  = a_addr;
        row.want.read_data   = rd;
        row.want.alloc_count = ac;
        row.want.free_count  = fc;
        row.want.deref_count = dc;
        directed_plan.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then log what it owes.
    task automatic send(input ffba_pkg::t_in_item it, input logic typed,
                        input ffba_pkg::t_out_item want);
        ffba_pkg::t_out_item got;
        int        idx;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = predict_allocator(it);
        owed_results.push_back(typed ? want : got);
        case (it.func)
            ffba_pkg::FN_ALLOC: begin
                n_alloc++;
                if (got.alloc_addr != 8'd0) begin
                    n_granted++;
                    live_starts.push_back(got.alloc_addr);
                end
            end
            ffba_pkg::FN_FREE: begin
                n_free++;
                idx = -1;
                foreach (live_starts[k])
                    if (live_starts[k] == it.addr)
                        idx = k;
                if (idx >= 0)
                    live_starts.delete(idx);
            end
            ffba_pkg::FN_WR_VAL: begin
                n_access++;
                if (!val_seen[it.addr]) begin
                    val_seen[it.addr] = 1'b1;
                    val_addrs.push_back(it.addr);
                end
            end
            ffba_pkg::FN_WR_LINK: begin
                n_access++;
                if (!link_seen[it.addr]) begin
                    link_seen[it.addr] = 1'b1;
                    link_addrs.push_back(it.addr);
                end
            end
            ffba_pkg::FN_RD_VAL, ffba_pkg::FN_RD_LINK: n_access++;
            ffba_pkg::FN_CLEAR: n_clear++;
            default: n_spare++;
        endcase
    endtask

    // Result side: stall at random, compare each taken item with the oldest owed one.
    always @(posedge clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: alloc_addr %0d read_data %0d",
                       out_item.alloc_addr, out_item.read_data);
                fail_count++;
            end else begin
                oldest = owed_results.pop_front();
                if (out_item.alloc_addr !== oldest.alloc_addr) begin
                    $error("alloc_addr: expected %0d, got %0d",
                           oldest.alloc_addr, out_item.alloc_addr);
                    fail_count++;
                end
                if (out_item.read_data !== oldest.read_data) begin
                    $error("read_data: expected %0d, got %0d",
                           oldest.read_data, out_item.read_data);
                    fail_count++;
                end
                if (out_item.alloc_count !== oldest.alloc_count) begin
                    $error("alloc_count: expected %0d, got %0d",
                           oldest.alloc_count, out_item.alloc_count);
                    fail_count++;
                end
                if (out_item.free_count !== oldest.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           oldest.free_count, out_item.free_count);
                    fail_count++;
                end
                if (out_item.deref_count !== oldest.deref_count) begin
                    $error("deref_count: expected %0d, got %0d",
                           oldest.deref_count, out_item.deref_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("** first_fit_block_allocator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        // Shadow state after reset: every block free, counters zero.
        foreach (run_map[b]) begin
            run_map[b]     = '0;
            value_words[b] = '0;
            link_words[b]  = '0;
        end
        allocs_seen   = '0;
        frees_seen    = '0;
        accesses_seen = '0;

        // Directed rows: func, addr, size, data, typed, then the obvious result.
        // Size zero refuses; one run covering every block but block 0; then no room.
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd0,   32'h0,        1, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd255, 32'h0,        1, 8'd1, 32'h0,   1, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd1,   32'h0,        1, 8'd0, 32'h0,   1, 0, 0);
        add_row(ffba_pkg::FN_FREE,    8'd1,   8'd0,   32'h0,        1, 8'd0, 32'h0,   1, 1, 0);
        // Free of a block that starts no run still counts.
        add_row(ffba_pkg::FN_FREE,    8'd0,   8'd0,   32'h0,        1, 8'd0, 32'h0,   1, 2, 0);
        // Word access at both address extremes with extreme data.
        add_row(ffba_pkg::FN_WR_VAL,  8'd0,   8'd0,   32'h7fffffff, 1, 8'd0, 32'h0,   1, 2, 1);
        add_row(ffba_pkg::FN_RD_VAL,  8'd0,   8'd0,   32'h0,        1, 8'd0, 32'h7fffffff,
                1, 2, 2);
        add_row(ffba_pkg::FN_WR_LINK, 8'd255, 8'd0,   32'h80000000, 1, 8'd0, 32'h0,   1, 2, 3);
        add_row(ffba_pkg::FN_RD_LINK, 8'd255, 8'd0,   32'h0,        1, 8'd0, 32'h80000000,
                1, 2, 4);
        add_row(ffba_pkg::FN_WR_VAL,  8'd255, 8'd0,   32'hffffffff, 1, 8'd0, 32'h0,   1, 2, 5);
        add_row(ffba_pkg::FN_RD_VAL,  8'd255, 8'd0,   32'h0,        1, 8'd0, 32'hffffffff,
                1, 2, 6);
        // Spare func code changes nothing.
        add_row(FN_SPARE,             8'd255, 8'd255, 32'hffffffff, 1, 8'd0, 32'h0,   1, 2, 6);
        add_row(ffba_pkg::FN_CLEAR,   8'd0,   8'd0,   32'h0,        1, 8'd0, 32'h0,   0, 0, 0);
        // Pack runs, hit the store end, punch a hole and refill it.
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd1,   32'h0,        1, 8'd1, 32'h0,   1, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd3,   32'h0,        0, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd251, 32'h0,        0, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd1,   32'h0,        0, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_FREE,    8'd2,   8'd0,   32'h0,        1, 8'd0, 32'h0,   3, 1, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd4,   32'h0,        0, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd3,   32'h0,        0, 8'd0, 32'h0,   0, 0, 0);
        add_row(ffba_pkg::FN_FREE,    8'd5,   8'd0,   32'h0,        1, 8'd0, 32'h0,   4, 2, 0);
        add_row(ffba_pkg::FN_FREE,    8'd2,   8'd0,   32'h0,        1, 8'd0, 32'h0,   4, 3, 0);
        add_row(ffba_pkg::FN_FREE,    8'd1,   8'd0,   32'h0,        1, 8'd0, 32'h0,   4, 4, 0);
        add_row(ffba_pkg::FN_ALLOC,   8'd0,   8'd255, 32'h0,        1, 8'd1, 32'h0,   5, 4, 0);
        add_row(ffba_pkg::FN_FREE,    8'd1,   8'd0,   32'h0,        1, 8'd0, 32'h0,   5, 5, 0);

        // Hold reset, then release it once.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
            send(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].want);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle <= (i >= STEADY_FIRST && i < STEADY_LAST);
            send(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        no_idle  <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items: %0d allocs (%0d granted), %0d frees, %0d word accesses,",
                 directed_plan.size() + RANDOM_ITEMS, n_alloc, n_granted, n_free, n_access);
        $display("  %0d counter clears, %0d spare codes; %0d mismatches",
                 n_clear, n_spare, fail_count);
        if (fail_count == 0)
            $display("** first_fit_block_allocator_unit: PASSED **");
        else
            $display("** first_fit_block_allocator_unit: FAILED **");
        $finish;
    end

endmodule
